### hdl/vcd_pkg.sv
// vcd_pkg: shared constants, types and microcode word layout for the change dispenser
// used by every module under hdl but vcd_checker; depends on nothing else
`timescale 1ns / 1ps

package vcd_pkg;

  localparam int STOCK_BITS = 16;
  localparam int NUM_DENOM  = 5;
  localparam int NUM_DRINKS = 5;
  localparam int PAID_W     = 8;
  localparam int PRICE_W    = 14;
  localparam int SEL_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int OUT_W      = 16;
  localparam int DEN_IDX_W  = 3;
  localparam int DENOM_W    = 10;
  localparam int CFG_ADDR_W = 3;

  // 255 pieces of every denomination: 423300 yen
  localparam int TOTAL_W    = 19;
  // reciprocal scaling for division by a denomination
  localparam int RECIP_S    = 20;
  localparam int RCP_W      = 17;
  localparam int PROD_W     = TOTAL_W + RCP_W;
  localparam int Q_W        = PROD_W - RECIP_S;
  localparam int MX_W       = (STOCK_BITS > TOTAL_W) ? STOCK_BITS : TOTAL_W;

  localparam int IN_DATA_W  = NUM_DENOM * PAID_W;
  localparam int OUT_DATA_W = 2 * NUM_DENOM * OUT_W;

  localparam int PC_W       = 5;
  localparam logic [PC_W-1:0] PC_END = PC_W'(27);

  localparam logic [DENOM_W-1:0] DENOM_VAL [NUM_DENOM] =
    '{DENOM_W'(1000), DENOM_W'(500), DENOM_W'(100), DENOM_W'(50), DENOM_W'(10)};

  localparam logic [RCP_W-1:0] DENOM_RCP [NUM_DENOM] =
    '{RCP_W'((1 << RECIP_S) / 1000), RCP_W'((1 << RECIP_S) / 500),
      RCP_W'((1 << RECIP_S) / 100), RCP_W'((1 << RECIP_S) / 50),
      RCP_W'((1 << RECIP_S) / 10)};

  localparam logic [STOCK_BITS-1:0] STOCK_RST [NUM_DENOM] =
    '{STOCK_BITS'(0), STOCK_BITS'(10), STOCK_BITS'(10), STOCK_BITS'(10), STOCK_BITS'(10)};

  localparam logic [PRICE_W-1:0] PRICE_RST [NUM_DRINKS] =
    '{PRICE_W'(110), PRICE_W'(140), PRICE_W'(210), PRICE_W'(190), PRICE_W'(120)};

  typedef enum logic [STATUS_W-1:0] {
    ST_CHANGE   = 2'd0,
    ST_EXACT    = 2'd1,
    ST_SHORT    = 2'd2,
    ST_NOCHANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_ACC,
    OP_CMP,
    OP_MUL,
    OP_QEST,
    OP_FIX,
    OP_APPLY,
    OP_CHECK,
    OP_END
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [DEN_IDX_W-1:0] den;
    logic                 jmp;
    logic [PC_W-1:0]      tgt;
    logic                 last;
  } ucw_t;

  typedef struct packed {
    logic jump;
    logic stall;
  } dp_stat_t;

  typedef struct packed {
    logic start;
    logic run;
  } seq_ctl_t;

endpackage

### hdl/vcd_ucode_rom.sv
// vcd_ucode_rom: read-only control program, one control word per step
// depends on vcd_pkg
`timescale 1ns / 1ps

module vcd_ucode_rom import vcd_pkg::*; (
  input  logic [PC_W-1:0] pc,
  output ucw_t            uw
);

  function automatic ucw_t mk(op_t op, logic [DEN_IDX_W-1:0] den, logic jmp, logic last);
    ucw_t w;
    w.op   = op;
    w.den  = den;
    w.jmp  = jmp;
    w.tgt  = PC_END;
    w.last = last;
    return w;
  endfunction

  always_comb begin
    case (pc)
      // paid total and saturated working stock
      5'd0:  uw = mk(OP_ACC,   3'd0, 1'b0, 1'b0);
      5'd1:  uw = mk(OP_ACC,   3'd1, 1'b0, 1'b0);
      5'd2:  uw = mk(OP_ACC,   3'd2, 1'b0, 1'b0);
      5'd3:  uw = mk(OP_ACC,   3'd3, 1'b0, 1'b0);
      5'd4:  uw = mk(OP_ACC,   3'd4, 1'b0, 1'b0);
      // short or exact money skips the change loop
      5'd5:  uw = mk(OP_CMP,   3'd0, 1'b1, 1'b0);
      5'd6:  uw = mk(OP_MUL,   3'd0, 1'b0, 1'b0);
      5'd7:  uw = mk(OP_QEST,  3'd0, 1'b0, 1'b0);
      5'd8:  uw = mk(OP_FIX,   3'd0, 1'b0, 1'b0);
      5'd9:  uw = mk(OP_APPLY, 3'd0, 1'b0, 1'b0);
      5'd10: uw = mk(OP_MUL,   3'd1, 1'b0, 1'b0);
      5'd11: uw = mk(OP_QEST,  3'd1, 1'b0, 1'b0);
      5'd12: uw = mk(OP_FIX,   3'd1, 1'b0, 1'b0);
      5'd13: uw = mk(OP_APPLY, 3'd1, 1'b0, 1'b0);
      5'd14: uw = mk(OP_MUL,   3'd2, 1'b0, 1'b0);
      5'd15: uw = mk(OP_QEST,  3'd2, 1'b0, 1'b0);
      5'd16: uw = mk(OP_FIX,   3'd2, 1'b0, 1'b0);
      5'd17: uw = mk(OP_APPLY, 3'd2, 1'b0, 1'b0);
      5'd18: uw = mk(OP_MUL,   3'd3, 1'b0, 1'b0);
      5'd19: uw = mk(OP_QEST,  3'd3, 1'b0, 1'b0);
      5'd20: uw = mk(OP_FIX,   3'd3, 1'b0, 1'b0);
      5'd21: uw = mk(OP_APPLY, 3'd3, 1'b0, 1'b0);
      5'd22: uw = mk(OP_MUL,   3'd4, 1'b0, 1'b0);
      5'd23: uw = mk(OP_QEST,  3'd4, 1'b0, 1'b0);
      5'd24: uw = mk(OP_FIX,   3'd4, 1'b0, 1'b0);
      5'd25: uw = mk(OP_APPLY, 3'd4, 1'b0, 1'b0);
      5'd26: uw = mk(OP_CHECK, 3'd0, 1'b0, 1'b0);
      5'd27: uw = mk(OP_END,   3'd0, 1'b0, 1'b1);
      default: uw = mk(OP_END, 3'd0, 1'b0, 1'b1);
    endcase
  end

endmodule

### hdl/vcd_sequencer.sv
// vcd_sequencer: step counter with conditional jump, and the input request handshake
// depends on vcd_pkg
`timescale 1ns / 1ps

module vcd_sequencer import vcd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ucw_t            uw,
  input  dp_stat_t        st,
  output logic [PC_W-1:0] pc,
  output seq_ctl_t        ctl
);

  logic            busy_r;
  logic [PC_W-1:0] pc_r;

  assign in_tready = ~busy_r;
  assign pc        = pc_r;
  assign ctl.start = in_tvalid & ~busy_r;
  assign ctl.run   = busy_r & ~st.stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else if (!busy_r) begin
      if (in_tvalid) begin
        busy_r <= 1'b1;
        pc_r   <= '0;
      end
    end else if (!st.stall) begin
      if (uw.last) begin
        busy_r <= 1'b0;
      end else if (uw.jmp && st.jump) begin
        pc_r <= uw.tgt;
      end else begin
        pc_r <= pc_r + PC_W'(1);
      end
    end
  end

endmodule

### hdl/vcd_datapath.sv
// vcd_datapath: price registers, coin stock, change arithmetic and result register
// depends on vcd_pkg; driven by the control word from vcd_ucode_rom
`timescale 1ns / 1ps

module vcd_datapath import vcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  seq_ctl_t              ctl,
  input  ucw_t                  uw,
  input  logic [SEL_W-1:0]      sel_in,
  input  logic [IN_DATA_W-1:0]  paid_in,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [PRICE_W-1:0]    cfg_wdata,
  output dp_stat_t              st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [STATUS_W-1:0]   out_status
);

  logic [PRICE_W-1:0]    price_r [NUM_DRINKS];
  logic [STOCK_BITS-1:0] stock_r [NUM_DENOM];
  logic [STOCK_BITS-1:0] work_r  [NUM_DENOM];
  logic [PAID_W-1:0]     paid_r  [NUM_DENOM];
  logic [TOTAL_W-1:0]    give_r  [NUM_DENOM];
  logic [SEL_W-1:0]      sel_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [TOTAL_W-1:0]    rem_r;
  logic [PROD_W-1:0]     prod_r;
  logic [Q_W-1:0]        q_r;
  logic [TOTAL_W-1:0]    qd_r;
  logic [TOTAL_W-1:0]    take_r;
  status_t               status_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic [DEN_IDX_W-1:0]  den;
  logic [DENOM_W-1:0]    dval;
  logic [SEL_W-1:0]      sel_sat;
  logic [TOTAL_W-1:0]    price_ext;
  logic [STOCK_BITS:0]   stock_sum;
  logic [STOCK_BITS-1:0] work_sat;
  logic [TOTAL_W-1:0]    acc_add;
  logic [TOTAL_W-1:0]    diff;
  logic [TOTAL_W-1:0]    q_fix;
  logic [MX_W-1:0]       take_mx;
  logic                  commit;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign den       = uw.den;
  assign dval      = DENOM_VAL[den];
  assign sel_sat   = (sel_r >= SEL_W'(NUM_DRINKS)) ? SEL_W'(NUM_DRINKS - 1) : sel_r;
  assign price_ext = TOTAL_W'(price_r[sel_sat]);

  // inserted pieces join the working stock, clipped at full scale
  assign stock_sum = {1'b0, stock_r[den]} + (STOCK_BITS + 1)'(paid_r[den]);
  assign work_sat  = stock_sum[STOCK_BITS] ? {STOCK_BITS{1'b1}} : stock_sum[STOCK_BITS-1:0];
  assign acc_add   = TOTAL_W'(paid_r[den]) * TOTAL_W'(dval);

  // reciprocal quotient is at most one low; one compare settles it
  assign diff    = rem_r - qd_r;
  assign q_fix   = TOTAL_W'(q_r) + TOTAL_W'(diff >= TOTAL_W'(dval));
  assign take_mx = (MX_W'(work_r[den]) < MX_W'(q_fix)) ? MX_W'(work_r[den]) : MX_W'(q_fix);

  assign commit   = (status_r == ST_CHANGE) || (status_r == ST_EXACT);
  assign st.jump  = (uw.op == OP_CMP) && (total_r <= price_ext);
  assign st.stall = (uw.op == OP_END) && out_valid_r && !out_ready;

  always_comb begin
    for (int j = 0; j < NUM_DENOM; j++) begin
      out_data_nxt[j*OUT_W +: OUT_W] = commit ? OUT_W'(give_r[j]) : OUT_W'(paid_r[j]);
      out_data_nxt[(NUM_DENOM+j)*OUT_W +: OUT_W] =
        commit ? OUT_W'(work_r[j]) : OUT_W'(stock_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      price_r     <= PRICE_RST;
      stock_r     <= STOCK_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen && (cfg_addr < CFG_ADDR_W'(NUM_DRINKS))) begin
        price_r[cfg_addr] <= cfg_wdata;
      end
      // a finishing step reloads the register in the same cycle
      if (out_valid_r && out_ready && !(ctl.run && (uw.op == OP_END))) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.start) begin
        sel_r   <= sel_in;
        total_r <= '0;
        for (int j = 0; j < NUM_DENOM; j++) begin
          paid_r[j] <= paid_in[j*PAID_W +: PAID_W];
          give_r[j] <= '0;
        end
      end
      if (ctl.run) begin
        case (uw.op)
          OP_ACC: begin
            total_r     <= total_r + acc_add;
            work_r[den] <= work_sat;
          end
          OP_CMP: begin
            rem_r <= total_r - price_ext;
            if (total_r < price_ext) begin
              status_r <= ST_SHORT;
            end else begin
              status_r <= ST_EXACT;
            end
          end
          OP_MUL: begin
            prod_r <= PROD_W'(rem_r) * PROD_W'(DENOM_RCP[den]);
          end
          OP_QEST: begin
            q_r  <= prod_r[RECIP_S +: Q_W];
            qd_r <= TOTAL_W'(prod_r[RECIP_S +: Q_W]) * TOTAL_W'(dval);
          end
          OP_FIX: begin
            take_r <= TOTAL_W'(take_mx);
          end
          OP_APPLY: begin
            give_r[den] <= take_r;
            work_r[den] <= work_r[den] - STOCK_BITS'(take_r);
            rem_r       <= rem_r - TOTAL_W'(take_r) * TOTAL_W'(dval);
          end
          OP_CHECK: begin
            status_r <= (rem_r != '0) ? ST_NOCHANGE : ST_CHANGE;
          end
          OP_END: begin
            if (commit) begin
              stock_r <= work_r;
            end
            out_valid_r  <= 1'b1;
            out_data_r   <= out_data_nxt;
            out_status_r <= status_r;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

endmodule

### hdl/vending_change_dispenser.sv
// vending_change_dispenser: top level, joins program rom, sequencer and datapath
// depends on vcd_pkg, vcd_ucode_rom, vcd_sequencer and vcd_datapath
`timescale 1ns / 1ps

// One purchase at a time: after a request is taken, in_tready stays low while a microcode
// program runs. When change is due the program takes 28 steps (five steps to total the
// money and top up the stock, one compare, four steps per denomination for the greedy
// change, one check and one finishing step). Short money and exact payment jump from the
// compare straight to the finishing step. The result sits in an output register; the next
// purchase is taken while it waits, but its finishing step holds until that register is
// free. The five drink prices may be rewritten through cfg_ only while no purchase is in
// flight.

module vending_change_dispenser import vcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // paid_thousands, paid_five_hundreds, paid_hundreds, paid_fifties, paid_tens
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // drink_select
  input  logic [SEL_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // back_thousands .. back_tens, then left_thousands .. left_tens
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [STATUS_W-1:0]   out_tuser,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [PRICE_W-1:0]    cfg_wdata
);

  logic [PC_W-1:0] pc;
  ucw_t            uw;
  dp_stat_t        st;
  seq_ctl_t        ctl;

  vcd_ucode_rom u_rom (
    .pc (pc),
    .uw (uw)
  );

  vcd_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .uw        (uw),
    .st        (st),
    .pc        (pc),
    .ctl       (ctl)
  );

  vcd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .uw         (uw),
    .sel_in     (in_tuser),
    .paid_in    (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .st         (st),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_status (out_tuser)
  );

endmodule

### hdl/vcd_checker.sv
// vcd_checker: port-level checks on the change dispenser, bound to the top level
// depends only on the ports of vending_change_dispenser
`timescale 1ns / 1ps

module vcd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [39:0]  in_tdata,
  input logic [2:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         cfg_wen,
  input logic [2:0]   cfg_addr,
  input logic [13:0]  cfg_wdata
);

  // nothing pending straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // one purchase at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while a purchase is in flight");

  // exact payment hands nothing back
  a_exact_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == 2'd1) |-> (out_tdata[79:0] == 80'd0))
    else $error("exact payment with pieces handed back");

  // change given means at least one piece back
  a_change_some_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == 2'd0) |-> (out_tdata[79:0] != 80'd0))
    else $error("change status with nothing handed back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind vending_change_dispenser vcd_checker u_chk (.*);
